// ===== hw/rtl/asg_pkg.sv =====
`timescale 1ns / 1ps

package asg_pkg;

	// Field widths of the request and of one schedule operation
	localparam int RANK_W = 10;
	localparam int GS_W   = 11;
	localparam int CNT_W  = 31;
	localparam int EB_W   = 16;
	localparam int CFG_W  = 32;
	localparam int KIND_W = 2;

	localparam int MAX_PROCS_DEF = 1024;

	localparam logic [CFG_W-1:0] SHORT_MSG_RST = 32'd2048;

	// Operation kinds on op_kind
	localparam logic [KIND_W-1:0] KIND_SEND     = 2'd0;
	localparam logic [KIND_W-1:0] KIND_RECV     = 2'd1;
	localparam logic [KIND_W-1:0] KIND_SENDRECV = 2'd2;

	// Datapath operations issued by the controller
	typedef enum logic [3:0] {
		DP_NOP      = 4'd0,
		DP_LOAD     = 4'd1,
		DP_SETUP    = 4'd2,
		DP_DECIDE   = 4'd3,
		DP_FOLD_IN  = 4'd4,
		DP_FOLD_OUT = 4'd5,
		DP_SHORT    = 4'd6,
		DP_RS_UPD   = 4'd7,
		DP_AG_UPD   = 4'd8,
		DP_MUL      = 4'd9,
		DP_RS_EMIT  = 4'd10,
		DP_AG_EMIT  = 4'd11
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
	} dp_cmd_t;

	typedef struct packed {
		logic none;       // request yields no operations
		logic fold;       // rank takes part in fold-in / fold-out
		logic skip_exch;  // even folded rank sits out the exchanges
		logic short_path; // recursive doubling instead of RS + AG
		logic rs_last;    // mask at pof2/2
		logic ag_last;    // mask at 1
	} dp_stat_t;

endpackage

// ===== hw/rtl/asg_ctrl.sv =====
`timescale 1ns / 1ps

module asg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  asg_pkg::dp_stat_t stat,
	output logic              busy,
	output asg_pkg::dp_cmd_t  cmd
);

	typedef enum logic [11:0] {
		ST_IDLE     = 12'h001,
		ST_SETUP    = 12'h002,
		ST_DECIDE   = 12'h004,
		ST_FOLD_IN  = 12'h008,
		ST_SHORT    = 12'h010,
		ST_RS_UPD   = 12'h020,
		ST_RS_MUL   = 12'h040,
		ST_RS_EMIT  = 12'h080,
		ST_AG_UPD   = 12'h100,
		ST_AG_MUL   = 12'h200,
		ST_AG_EMIT  = 12'h400,
		ST_FOLD_OUT = 12'h800
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = asg_pkg::DP_NOP;
		case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.op  = asg_pkg::DP_LOAD;
					state_d = ST_SETUP;
				end
			end
			ST_SETUP: begin
				cmd.op  = asg_pkg::DP_SETUP;
				state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.op = asg_pkg::DP_DECIDE;
				if (stat.none) begin
					state_d = ST_IDLE;
				end else if (stat.fold) begin
					state_d = ST_FOLD_IN;
				end else if (stat.short_path) begin
					state_d = ST_SHORT;
				end else begin
					state_d = ST_RS_UPD;
				end
			end
			ST_FOLD_IN: begin
				cmd.op = asg_pkg::DP_FOLD_IN;
				if (stat.skip_exch) begin
					state_d = ST_FOLD_OUT;
				end else if (stat.short_path) begin
					state_d = ST_SHORT;
				end else begin
					state_d = ST_RS_UPD;
				end
			end
			ST_SHORT: begin
				cmd.op = asg_pkg::DP_SHORT;
				if (stat.rs_last) begin
					state_d = stat.fold ? ST_FOLD_OUT : ST_IDLE;
				end
			end
			ST_RS_UPD: begin
				cmd.op  = asg_pkg::DP_RS_UPD;
				state_d = ST_RS_MUL;
			end
			ST_RS_MUL: begin
				cmd.op  = asg_pkg::DP_MUL;
				state_d = ST_RS_EMIT;
			end
			ST_RS_EMIT: begin
				cmd.op  = asg_pkg::DP_RS_EMIT;
				state_d = stat.rs_last ? ST_AG_UPD : ST_RS_UPD;
			end
			ST_AG_UPD: begin
				cmd.op  = asg_pkg::DP_AG_UPD;
				state_d = ST_AG_MUL;
			end
			ST_AG_MUL: begin
				cmd.op  = asg_pkg::DP_MUL;
				state_d = ST_AG_EMIT;
			end
			ST_AG_EMIT: begin
				cmd.op = asg_pkg::DP_AG_EMIT;
				if (stat.ag_last) begin
					state_d = stat.fold ? ST_FOLD_OUT : ST_IDLE;
				end else begin
					state_d = ST_AG_UPD;
				end
			end
			ST_FOLD_OUT: begin
				cmd.op  = asg_pkg::DP_FOLD_OUT;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);

endmodule

// ===== hw/rtl/asg_dp.sv =====
`timescale 1ns / 1ps

module asg_dp #(
	parameter int MAX_PROCS = asg_pkg::MAX_PROCS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  asg_pkg::dp_cmd_t                 cmd,
	output asg_pkg::dp_stat_t                stat,
	input  logic [asg_pkg::RANK_W-1:0]       rank,
	input  logic [asg_pkg::GS_W-1:0]         group_size,
	input  logic [asg_pkg::CNT_W-1:0]        element_count,
	input  logic [asg_pkg::EB_W-1:0]         element_bytes,
	input  logic                             cfg_we,
	input  logic [asg_pkg::CFG_W-1:0]        cfg_data,
	output logic                             result_valid,
	output logic [asg_pkg::KIND_W-1:0]       op_kind,
	output logic [asg_pkg::RANK_W-1:0]       peer,
	output logic [asg_pkg::CNT_W-1:0]        send_elements,
	output logic [asg_pkg::CNT_W-1:0]        recv_elements,
	output logic                             last
);

	localparam int RW    = asg_pkg::RANK_W;
	localparam int CW    = asg_pkg::CNT_W;
	localparam int PW    = $clog2(MAX_PROCS) + 1;
	localparam int NW    = (PW > asg_pkg::GS_W) ? PW : asg_pkg::GS_W;
	localparam int IW    = NW + 2;
	localparam int LW    = $clog2(NW);
	localparam int MUL_W = IW - 1 + CW;
	localparam int BY_W  = CW + asg_pkg::EB_W;

	// Request registers
	logic [RW-1:0]            rank_q;
	logic [asg_pkg::GS_W-1:0] gs_in_q;
	logic [CW-1:0]            count_q;
	logic [asg_pkg::EB_W-1:0] eb_q;

	// Setup results
	logic [NW-1:0]   gs_q;
	logic [NW-1:0]   pof2_q;
	logic [LW-1:0]   lg_q;
	logic [NW-1:0]   rem_q;
	logic [BY_W-1:0] bytes_q;

	// Exchange state
	logic [NW-1:0]          newrank_q;
	logic [CW-1:0]          q_q;
	logic [NW-1:0]          mask_q;
	logic [NW-1:0]          half_q;
	logic signed [IW-1:0]   sidx_q;
	logic signed [IW-1:0]   ridx_q;
	logic signed [IW-1:0]   lidx_q;
	logic                   patx_q;
	logic [CW-1:0]          ps_q;
	logic [CW-1:0]          pr_q;
	logic [CW-1:0]          pl_q;

	logic [asg_pkg::CFG_W-1:0] short_msg_q;
	logic                      result_valid_q;
	logic [asg_pkg::KIND_W-1:0] op_kind_q;
	logic [RW-1:0]              peer_q;
	logic [CW-1:0]              send_q;
	logic [CW-1:0]              recv_q;
	logic                       last_q;

	// Setup logic
	logic [NW-1:0]   gs_ext;
	logic [NW-1:0]   gs_c;
	logic [LW-1:0]   lg_c;
	logic [NW-1:0]   pof2_c;
	logic [BY_W-1:0] bytes_c;

	// Step logic
	logic [NW-1:0]        nd;
	logic [NW-1:0]        real_rank;
	logic                 low;
	logic signed [IW-1:0] half_s;
	logic [RW-1:0]        rank_p1;
	logic [RW-1:0]        rank_m1;
	logic [CW-1:0]        span_s;
	logic [CW-1:0]        span_r;
	logic                 emit;
	logic [asg_pkg::KIND_W-1:0] kind_d;
	logic [RW-1:0]              peer_d;
	logic [CW-1:0]              send_d;
	logic [CW-1:0]              recv_d;
	logic                       last_d;

	// Elements held by blocks [0, idx)
	function automatic logic [CW-1:0] prefix_f(
		input logic signed [IW-1:0] idx,
		input logic [NW-1:0]        p2,
		input logic [CW-1:0]        qv,
		input logic [CW-1:0]        cnt
	);
		logic [MUL_W-1:0] prod;
		logic [CW-1:0]    res;
		prod = MUL_W'(idx[IW-2:0]) * MUL_W'(qv);
		if (idx[IW-1] || (idx[IW-2:0] == '0)) begin
			res = '0;
		end else if (idx >= $signed({2'b00, p2})) begin
			res = cnt;
		end else begin
			res = prod[CW-1:0];
		end
		return res;
	endfunction

	always_comb begin
		gs_ext = NW'(gs_in_q);
		gs_c   = (gs_ext > NW'(MAX_PROCS)) ? NW'(MAX_PROCS) : gs_ext;
		lg_c   = '0;
		for (int i = 0; i < NW; i++) begin
			if (gs_c[i]) begin
				lg_c = LW'(i);
			end
		end
		pof2_c  = NW'(1) << lg_c;
		bytes_c = BY_W'(count_q) * BY_W'(eb_q);
	end

	always_comb begin
		stat.none       = (gs_q <= NW'(1)) || (NW'(rank_q) >= gs_q);
		stat.fold       = NW'(rank_q) < (rem_q << 1);
		stat.skip_exch  = stat.fold && !rank_q[0];
		stat.short_path = (bytes_q <= BY_W'(short_msg_q)) || (count_q < CW'(pof2_q));
		stat.rs_last    = (mask_q == (pof2_q >> 1));
		stat.ag_last    = (mask_q == NW'(1));
	end

	always_comb begin
		nd        = newrank_q ^ mask_q;
		real_rank = (nd < rem_q) ? ((nd << 1) | NW'(1)) : (nd + rem_q);
		low       = ((newrank_q & mask_q) == '0);
		half_s    = $signed({2'b00, half_q});
		rank_p1   = rank_q + RW'(1);
		rank_m1   = rank_q - RW'(1);
		if (patx_q) begin
			span_s = (lidx_q > sidx_q) ? (pl_q - ps_q) : '0;
			span_r = (sidx_q > ridx_q) ? (ps_q - pr_q) : '0;
		end else begin
			span_s = (ridx_q > sidx_q) ? (pr_q - ps_q) : '0;
			span_r = (lidx_q > ridx_q) ? (pl_q - pr_q) : '0;
		end
	end

	// Result selection
	always_comb begin
		emit   = 1'b0;
		kind_d = asg_pkg::KIND_SENDRECV;
		peer_d = real_rank[RW-1:0];
		send_d = span_s;
		recv_d = span_r;
		last_d = 1'b0;
		case (cmd.op)
			asg_pkg::DP_FOLD_IN: begin
				emit = 1'b1;
				if (rank_q[0]) begin
					kind_d = asg_pkg::KIND_RECV;
					peer_d = rank_m1;
					send_d = '0;
					recv_d = count_q;
				end else begin
					kind_d = asg_pkg::KIND_SEND;
					peer_d = rank_p1;
					send_d = count_q;
					recv_d = '0;
				end
			end
			asg_pkg::DP_FOLD_OUT: begin
				emit   = 1'b1;
				last_d = 1'b1;
				if (rank_q[0]) begin
					kind_d = asg_pkg::KIND_SEND;
					peer_d = rank_m1;
					send_d = count_q;
					recv_d = '0;
				end else begin
					kind_d = asg_pkg::KIND_RECV;
					peer_d = rank_p1;
					send_d = '0;
					recv_d = count_q;
				end
			end
			asg_pkg::DP_SHORT: begin
				emit   = 1'b1;
				send_d = count_q;
				recv_d = count_q;
				last_d = stat.rs_last && !stat.fold;
			end
			asg_pkg::DP_RS_EMIT: begin
				emit = 1'b1;
			end
			asg_pkg::DP_AG_EMIT: begin
				emit   = 1'b1;
				last_d = stat.ag_last && !stat.fold;
			end
			default: begin
				emit = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_msg_q    <= asg_pkg::SHORT_MSG_RST;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				short_msg_q <= cfg_data;
			end
			result_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			op_kind_q <= kind_d;
			peer_q    <= peer_d;
			send_q    <= send_d;
			recv_q    <= recv_d;
			last_q    <= last_d;
		end
		case (cmd.op)
			asg_pkg::DP_LOAD: begin
				rank_q  <= rank;
				gs_in_q <= group_size;
				count_q <= element_count;
				eb_q    <= element_bytes;
			end
			asg_pkg::DP_SETUP: begin
				gs_q    <= gs_c;
				pof2_q  <= pof2_c;
				lg_q    <= lg_c;
				rem_q   <= gs_c - pof2_c;
				bytes_q <= bytes_c;
			end
			asg_pkg::DP_DECIDE: begin
				newrank_q <= stat.fold ? NW'(rank_q >> 1) : (NW'(rank_q) - rem_q);
				q_q       <= count_q >> lg_q;
				mask_q    <= NW'(1);
				half_q    <= pof2_q >> 1;
				sidx_q    <= '0;
				ridx_q    <= '0;
				lidx_q    <= $signed({2'b00, pof2_q});
			end
			asg_pkg::DP_SHORT: begin
				mask_q <= mask_q << 1;
			end
			asg_pkg::DP_RS_UPD: begin
				patx_q <= low;
				if (low) begin
					sidx_q <= ridx_q + half_s;
				end else begin
					ridx_q <= sidx_q + half_s;
				end
			end
			asg_pkg::DP_AG_UPD: begin
				patx_q <= !low;
				if (low) begin
					if (mask_q != (pof2_q >> 1)) begin
						lidx_q <= lidx_q + half_s;
					end
					ridx_q <= sidx_q + half_s;
				end else begin
					ridx_q <= sidx_q - half_s;
				end
			end
			asg_pkg::DP_MUL: begin
				ps_q <= prefix_f(sidx_q, pof2_q, q_q, count_q);
				pr_q <= prefix_f(ridx_q, pof2_q, q_q, count_q);
				pl_q <= prefix_f(lidx_q, pof2_q, q_q, count_q);
			end
			asg_pkg::DP_RS_EMIT: begin
				sidx_q <= ridx_q;
				if (!stat.rs_last) begin
					mask_q <= mask_q << 1;
					half_q <= half_q >> 1;
					lidx_q <= ridx_q + half_s;
				end
			end
			asg_pkg::DP_AG_EMIT: begin
				if (!low) begin
					sidx_q <= ridx_q;
				end
				if (!stat.ag_last) begin
					mask_q <= mask_q >> 1;
					half_q <= half_q << 1;
				end
			end
			default: begin
			end
		endcase
	end

	assign result_valid  = result_valid_q;
	assign op_kind       = op_kind_q;
	assign peer          = peer_q;
	assign send_elements = send_q;
	assign recv_elements = recv_q;
	assign last          = last_q;

endmodule

// ===== hw/rtl/allreduce_schedule_generator_top.sv =====
`timescale 1ns / 1ps

// Allreduce schedule generator. Pulse start while busy is low to hand in one request
// (rank, group_size, element_count, element_bytes); the block then lists this rank's
// point-to-point operations for a recursive-doubling / reduce-scatter-allgather
// allreduce, one operation per result_valid pulse, with last set on the final one.
// The receiver cannot stall: every result shows for exactly one cycle and must be taken
// then. A group of one, or a rank not below the group size, gives no results at all.
// Order of work per request: setup (accept, power-of-two and byte-size evaluation,
// path decision), then each fold-in or fold-out operation, each step of the short
// path, and each step of the reduce-scatter and allgather path, where a step updates
// the block indices, forms three block prefixes on the multipliers and then emits.
// The next start is taken as soon as busy drops, while the final result is still on
// the ports. The short-message limit (reset 2048 bytes) is written through
// cfg_valid/cfg_ready/cfg_data; cfg_ready is high only while busy is low.
module allreduce_schedule_generator_top #(
	parameter int MAX_PROCS = asg_pkg::MAX_PROCS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [asg_pkg::RANK_W-1:0]    rank,
	input  logic [asg_pkg::GS_W-1:0]      group_size,
	input  logic [asg_pkg::CNT_W-1:0]     element_count,
	input  logic [asg_pkg::EB_W-1:0]      element_bytes,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [asg_pkg::CFG_W-1:0]     cfg_data,
	output logic                          result_valid,
	output logic [asg_pkg::KIND_W-1:0]    op_kind,
	output logic [asg_pkg::RANK_W-1:0]    peer,
	output logic [asg_pkg::CNT_W-1:0]     send_elements,
	output logic [asg_pkg::CNT_W-1:0]     recv_elements,
	output logic                          last
);

	asg_pkg::dp_cmd_t  cmd;
	asg_pkg::dp_stat_t stat;
	logic              cfg_we;

	// Take configuration transactions only between requests
	assign cfg_ready = !busy;
	assign cfg_we    = cfg_valid && cfg_ready;

	// Sequencer: walks fold-in, exchange steps and fold-out
	asg_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.busy   (busy),
		.cmd    (cmd)
	);

	// Index arithmetic, block prefixes and the result register
	asg_dp #(
		.MAX_PROCS (MAX_PROCS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.rank          (rank),
		.group_size    (group_size),
		.element_count (element_count),
		.element_bytes (element_bytes),
		.cfg_we        (cfg_we),
		.cfg_data      (cfg_data),
		.result_valid  (result_valid),
		.op_kind       (op_kind),
		.peer          (peer),
		.send_elements (send_elements),
		.recv_elements (recv_elements),
		.last          (last)
	);

endmodule

// ===== hw/rtl/asg_checker.sv =====
`timescale 1ns / 1ps

module asg_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       start,
	input logic                       busy,
	input logic                       result_valid,
	input logic [asg_pkg::KIND_W-1:0] op_kind,
	input logic [asg_pkg::CNT_W-1:0]  send_elements,
	input logic [asg_pkg::CNT_W-1:0]  recv_elements,
	input logic                       last
);

	// An accepted request keeps the block busy in the next cycle
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted request did not raise busy");

	// A result seen while idle can only be the final one of a schedule
	a_idle_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !busy |-> last)
		else $error("result while idle is not the final one");

	// Nothing follows the final result directly
	a_last_gap: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && last |=> !result_valid)
		else $error("result right after the final one");

	// Pure sends carry nothing back, pure receives send nothing
	a_send_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (op_kind == asg_pkg::KIND_SEND) |-> (recv_elements == '0))
		else $error("send with nonzero receive count");

	a_recv_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (op_kind == asg_pkg::KIND_RECV) |-> (send_elements == '0))
		else $error("receive with nonzero send count");

endmodule

bind allreduce_schedule_generator_top asg_checker u_asg_checker (.*);
